@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lbg_pkg.sv @@
// Types and constants shared by the LED bar gauge modules.
package lbg_pkg;

    localparam int LED_W      = 7;
    localparam int IDX_W      = 10;
    localparam int PERIOD_W   = 16;
    localparam int PHASE_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int FILL_W     = 17;
    localparam int TIME_W     = 32;
    localparam int DIV_STEPS  = TIME_W + PHASE_W;
    localparam int STEP_W     = 6;
    localparam int POS_STEPS  = PHASE_W;
    localparam int POS_STEP_W = 4;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(65536);

    localparam logic [2:0] REG_SEG_FIRST   = 3'd0;
    localparam logic [2:0] REG_SEG_FINAL   = 3'd1;
    localparam logic [2:0] REG_PERIOD      = 3'd2;
    localparam logic [2:0] REG_BRIGHT_LOW  = 3'd3;
    localparam logic [2:0] REG_BRIGHT_HIGH = 3'd4;

    typedef struct packed {
        logic [IDX_W-1:0]    seg_first;
        logic [IDX_W-1:0]    seg_final;
        logic [PERIOD_W-1:0] period;
        logic [COLOR_W-1:0]  bright_low;
        logic [COLOR_W-1:0]  bright_high;
    } cfg_t;

    // One frame as handed from the front end to the pixel engine.
    typedef struct packed {
        logic                forward;
        logic [IDX_W-1:0]    seg_first;
        logic [LED_W-1:0]    len;
        logic [LED_W-1:0]    lit;
        logic [PHASE_W-1:0]  phase;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [COLOR_W-1:0]  bright_low;
        logic [COLOR_W-1:0]  span;
    } frame_t;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_DIV,
        BK_WAVE,
        BK_BRIGHT,
        BK_EMIT
    } back_state_t;

endpackage

@@ rtl/lbg_fifo.sv @@
// Two-entry frame queue between the front end and the pixel engine.
module lbg_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lbg_pkg::frame_t wr_data,
    input  logic           pop,
    output lbg_pkg::frame_t rd_data,
    output logic           full,
    output logic           empty
);
    import lbg_pkg::*;

    frame_t     mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (cnt_reg == 2'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == 2'd0);

endmodule

@@ rtl/lbg_front.sv @@
// Front end: takes a frame request, sizes the segment and finds the wave phase.
module lbg_front #(
    parameter int MAX_LEDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lbg_pkg::FILL_W-1:0]    fill_level,
    input  logic [lbg_pkg::TIME_W-1:0]    time_ms,
    input  logic [lbg_pkg::COLOR_W-1:0]   base_red,
    input  logic [lbg_pkg::COLOR_W-1:0]   base_green,
    input  logic [lbg_pkg::COLOR_W-1:0]   base_blue,
    input  lbg_pkg::cfg_t                 cfg,
    output lbg_pkg::frame_t               frame,
    output logic                          push,
    input  logic                          full
);
    import lbg_pkg::*;

    localparam logic [LED_W-1:0] MaxLen = LED_W'(MAX_LEDS);

    front_state_t                state_reg;
    front_state_t                state_next;
    frame_t                      frame_reg;
    frame_t                      frame_next;
    logic [PERIOD_W:0]           rem_reg;
    logic [PERIOD_W:0]           rem_next;
    logic [DIV_STEPS-1:0]        dvd_reg;
    logic [DIV_STEPS-1:0]        dvd_next;
    logic [PHASE_W-1:0]          quot_reg;
    logic [PHASE_W-1:0]          quot_next;
    logic [STEP_W-1:0]           step_reg;
    logic [STEP_W-1:0]           step_next;

    logic                        accept;
    logic                        forward;
    logic [IDX_W-1:0]            diff;
    logic [IDX_W:0]              len_raw;
    logic [LED_W-1:0]            len;
    logic [FILL_W-1:0]           fill_sat;
    logic [23:0]                 lit_sum;
    logic [7:0]                  lit_min;
    logic [LED_W-1:0]            lit;
    logic [COLOR_W-1:0]          span;
    logic [PERIOD_W:0]           trial;
    logic                        ge;

    assign accept  = start && (state_reg == FR_IDLE);
    assign forward = (cfg.seg_final >= cfg.seg_first);
    assign diff    = forward ? (cfg.seg_final - cfg.seg_first) : (cfg.seg_first - cfg.seg_final);
    assign len_raw = {1'b0, diff} + 11'd1;
    assign len     = (len_raw > 11'(MAX_LEDS)) ? MaxLen : len_raw[LED_W-1:0];

    // Lit count rounds to nearest, with at least one LED for any nonzero fill.
    assign fill_sat = (fill_level > FILL_FULL) ? FILL_FULL : fill_level;
    assign lit_sum  = 24'(fill_sat) * 24'(len) + 24'd32768;
    assign lit_min  = ((fill_sat != '0) && (lit_sum[23:16] == 8'd0)) ? 8'd1 : lit_sum[23:16];
    assign lit      = (lit_min > {1'b0, len}) ? len : lit_min[LED_W-1:0];
    assign span     = (cfg.bright_high > cfg.bright_low) ? (cfg.bright_high - cfg.bright_low)
                                                         : '0;

    // One restoring step of (time << 16) / period; the low 16 quotient bits
    // are the phase, the integer turns drop out.
    assign trial = {rem_reg[PERIOD_W-1:0], dvd_reg[DIV_STEPS-1]};
    assign ge    = (trial >= {1'b0, cfg.period});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cfg.period == '0) ? FR_PUSH : FR_DIV;
                end
            end
            FR_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        frame_next = frame_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    frame_next.forward    = forward;
                    frame_next.seg_first  = cfg.seg_first;
                    frame_next.len        = len;
                    frame_next.lit        = lit;
                    frame_next.phase      = '0;
                    frame_next.red        = base_red;
                    frame_next.green      = base_green;
                    frame_next.blue       = base_blue;
                    frame_next.bright_low = cfg.bright_low;
                    frame_next.span       = span;
                    rem_next              = '0;
                    dvd_next              = {time_ms, {PHASE_W{1'b0}}};
                    quot_next             = '0;
                    step_next             = '0;
                end
            end
            FR_DIV:
            begin
                rem_next  = ge ? (trial - {1'b0, cfg.period}) : trial;
                dvd_next  = {dvd_reg[DIV_STEPS-2:0], 1'b0};
                quot_next = {quot_reg[PHASE_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
            end
            FR_PUSH:
            begin
                frame_next.phase = quot_reg;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
    end

    always_comb
    begin
        frame       = frame_reg;
        frame.phase = quot_reg;
    end

    assign push = (state_reg == FR_PUSH) && !full;
    assign busy = (state_reg != FR_IDLE);

endmodule

@@ rtl/lbg_back.sv @@
// Pixel engine: walks the segment of one frame and emits one pixel word per LED.
module lbg_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lbg_pkg::frame_t               frame,
    input  logic                          empty,
    output logic                          pop,
    output logic                          pixel_valid,
    output logic [lbg_pkg::IDX_W-1:0]     led_index,
    output logic [lbg_pkg::COLOR_W-1:0]   pixel_red,
    output logic [lbg_pkg::COLOR_W-1:0]   pixel_green,
    output logic [lbg_pkg::COLOR_W-1:0]   pixel_blue,
    output logic                          last_pixel
);
    import lbg_pkg::*;

    back_state_t             state_reg;
    back_state_t             state_next;
    frame_t                  desc_reg;
    frame_t                  desc_next;
    logic [LED_W-1:0]        idx_reg;
    logic [LED_W-1:0]        idx_next;
    logic [LED_W-1:0]        rem_reg;
    logic [LED_W-1:0]        rem_next;
    logic [PHASE_W-1:0]      quot_reg;
    logic [PHASE_W-1:0]      quot_next;
    logic [POS_STEP_W-1:0]   step_reg;
    logic [POS_STEP_W-1:0]   step_next;
    logic [PHASE_W:0]        w2_reg;
    logic [PHASE_W:0]        w2_next;
    logic [COLOR_W-1:0]      bright_reg;
    logic [COLOR_W-1:0]      bright_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic [IDX_W-1:0]        index_reg;
    logic [IDX_W-1:0]        index_next;
    logic [COLOR_W-1:0]      red_reg;
    logic [COLOR_W-1:0]      red_next;
    logic [COLOR_W-1:0]      green_reg;
    logic [COLOR_W-1:0]      green_next;
    logic [COLOR_W-1:0]      blue_reg;
    logic [COLOR_W-1:0]      blue_next;
    logic                    last_reg;
    logic                    last_next;

    logic                    lit_px;
    logic                    last_px;
    logic [LED_W:0]          trial;
    logic [LED_W:0]          trial_sub;
    logic                    ge;
    logic [PHASE_W-1:0]      x;
    logic [PHASE_W:0]        neg;
    logic [PHASE_W:0]        wave;
    logic [2*PHASE_W+1:0]    wave_sq;
    logic [24:0]             bright_prod;
    logic [9:0]              bright_sum;

    // Nonzero channels stay nonzero as long as the brightness is nonzero.
    function automatic logic [COLOR_W-1:0] video_scale(
        input logic [COLOR_W-1:0] c,
        input logic [COLOR_W-1:0] b
    );
        logic [2*COLOR_W-1:0] prod;
        prod = c * b;
        if (c == '0)
        begin
            return '0;
        end
        return prod[2*COLOR_W-1:COLOR_W] + COLOR_W'(b != '0);
    endfunction

    assign lit_px  = (idx_reg < desc_reg.lit);
    assign last_px = ((idx_reg + LED_W'(1)) == desc_reg.len);

    // Position i/lit in Q16: remainder starts at i, which is below lit.
    assign trial     = {rem_reg, 1'b0};
    assign trial_sub = trial - {1'b0, desc_reg.lit};
    assign ge        = (trial >= {1'b0, desc_reg.lit});

    // Triangle 65536 - |2x - 65536| folded into two cases on the top bit of x.
    assign x       = quot_reg - desc_reg.phase;
    assign neg     = 17'h10000 - {1'b0, x};
    assign wave    = x[PHASE_W-1] ? {neg[PHASE_W-1:0], 1'b0} : {x, 1'b0};
    assign wave_sq = wave * wave;

    assign bright_prod = w2_reg * desc_reg.span;
    assign bright_sum  = 10'(desc_reg.bright_low) + 10'(bright_prod[24:16]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = BK_SETUP;
                end
            end
            BK_SETUP:
            begin
                state_next = lit_px ? BK_DIV : BK_EMIT;
            end
            BK_DIV:
            begin
                if (step_reg == POS_STEP_W'(POS_STEPS - 1))
                begin
                    state_next = BK_WAVE;
                end
            end
            BK_WAVE:
            begin
                state_next = BK_BRIGHT;
            end
            BK_BRIGHT:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                state_next = last_px ? BK_IDLE : BK_SETUP;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        desc_next   = desc_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        step_next   = step_reg;
        w2_next     = w2_reg;
        bright_next = bright_reg;
        valid_next  = 1'b0;
        index_next  = index_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    desc_next = frame;
                    idx_next  = '0;
                end
            end
            BK_SETUP:
            begin
                rem_next  = idx_reg;
                quot_next = '0;
                step_next = '0;
            end
            BK_DIV:
            begin
                rem_next  = ge ? trial_sub[LED_W-1:0] : trial[LED_W-1:0];
                quot_next = {quot_reg[PHASE_W-2:0], ge};
                step_next = step_reg + POS_STEP_W'(1);
            end
            BK_WAVE:
            begin
                w2_next = wave_sq[2*PHASE_W:PHASE_W];
            end
            BK_BRIGHT:
            begin
                bright_next = (bright_sum > 10'd255) ? 8'd255 : bright_sum[COLOR_W-1:0];
            end
            BK_EMIT:
            begin
                valid_next = 1'b1;
                index_next = desc_reg.forward ? (desc_reg.seg_first + IDX_W'(idx_reg))
                                              : (desc_reg.seg_first - IDX_W'(idx_reg));
                red_next   = lit_px ? video_scale(desc_reg.red, bright_reg) : '0;
                green_next = lit_px ? video_scale(desc_reg.green, bright_reg) : '0;
                blue_next  = lit_px ? video_scale(desc_reg.blue, bright_reg) : '0;
                last_next  = last_px;
                idx_next   = idx_reg + LED_W'(1);
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg   <= desc_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        w2_reg     <= w2_next;
        bright_reg <= bright_next;
        index_reg  <= index_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        last_reg   <= last_next;
    end

    assign pixel_valid = valid_reg;
    assign led_index   = index_reg;
    assign pixel_red   = red_reg;
    assign pixel_green = green_reg;
    assign pixel_blue  = blue_reg;
    assign last_pixel  = last_reg;

endmodule

@@ rtl/led_bar_gauge_wave_fill_core.sv @@
// Top level of the LED bar gauge with a travelling brightness wave.
//
// A frame request (fill_level, time_ms, base colour) is taken at a clock edge
// where start is high and busy is low. The block then emits one pixel word per
// LED of the configured segment (MAX_LEDS at most), in segment order, each on
// the result ports for one cycle with pixel_valid high; last_pixel marks the
// final word. The receiver cannot hold words off, so none is ever stalled.
// The front end holds busy after a request while it works out the wave phase
// bit by bit (48 steps of one divider) and until the frame goes into the
// queue, which waits while the queue is full; a zero period skips the
// divider. A two-frame queue sits between front end and pixel engine, so the
// next request is taken while pixels still go out.
// For each frame the pixel engine pops the queue, then for each lit LED runs
// setup, the position divider (one quotient bit a step), the wave and the
// brightness steps and emit, and for a dark LED only setup and emit.
// Configuration registers sit on the APB port at byte address 4*index; pready
// is always high. Reset clears the control state and loads the register
// defaults; no frame is in flight after reset.
module led_bar_gauge_wave_fill_core #(
    parameter int MAX_LEDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lbg_pkg::FILL_W-1:0]    fill_level,
    input  logic [lbg_pkg::TIME_W-1:0]    time_ms,
    input  logic [lbg_pkg::COLOR_W-1:0]   base_red,
    input  logic [lbg_pkg::COLOR_W-1:0]   base_green,
    input  logic [lbg_pkg::COLOR_W-1:0]   base_blue,
    output logic                          pixel_valid,
    output logic [lbg_pkg::IDX_W-1:0]     led_index,
    output logic [lbg_pkg::COLOR_W-1:0]   pixel_red,
    output logic [lbg_pkg::COLOR_W-1:0]   pixel_green,
    output logic [lbg_pkg::COLOR_W-1:0]   pixel_blue,
    output logic                          last_pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lbg_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   wr_en;
    frame_t front_frame;
    frame_t queue_frame;
    logic   queue_push;
    logic   queue_pop;
    logic   queue_full;
    logic   queue_empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_SEG_FIRST:   cfg_next.seg_first   = pwdata[IDX_W-1:0];
                REG_SEG_FINAL:   cfg_next.seg_final   = pwdata[IDX_W-1:0];
                REG_PERIOD:      cfg_next.period      = pwdata[PERIOD_W-1:0];
                REG_BRIGHT_LOW:  cfg_next.bright_low  = pwdata[COLOR_W-1:0];
                REG_BRIGHT_HIGH: cfg_next.bright_high = pwdata[COLOR_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_first   <= IDX_W'(0);
            cfg_reg.seg_final   <= IDX_W'(15);
            cfg_reg.period      <= PERIOD_W'(1000);
            cfg_reg.bright_low  <= COLOR_W'(20);
            cfg_reg.bright_high <= COLOR_W'(255);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SEG_FIRST:   prdata = 32'(cfg_reg.seg_first);
            REG_SEG_FINAL:   prdata = 32'(cfg_reg.seg_final);
            REG_PERIOD:      prdata = 32'(cfg_reg.period);
            REG_BRIGHT_LOW:  prdata = 32'(cfg_reg.bright_low);
            REG_BRIGHT_HIGH: prdata = 32'(cfg_reg.bright_high);
            default:         prdata = '0;
        endcase
    end

    lbg_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .fill_level (fill_level),
        .time_ms    (time_ms),
        .base_red   (base_red),
        .base_green (base_green),
        .base_blue  (base_blue),
        .cfg        (cfg_reg),
        .frame      (front_frame),
        .push       (queue_push),
        .full       (queue_full)
    );

    lbg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (queue_push),
        .wr_data (front_frame),
        .pop     (queue_pop),
        .rd_data (queue_frame),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    lbg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (queue_frame),
        .empty       (queue_empty),
        .pop         (queue_pop),
        .pixel_valid (pixel_valid),
        .led_index   (led_index),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .last_pixel  (last_pixel)
    );

endmodule

@@ rtl/lbg_checker.sv @@
// Port-level checks for the LED bar gauge, bound to the top level.
`include "assert_macros.svh"

module lbg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        pixel_valid,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A taken request keeps the front end busy while the phase is worked out.
    `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "busy low after a request")

    // Pixel words never come out back to back.
    `ASSERT_NEXT(a_word_gap, clk, rst_n, pixel_valid, !pixel_valid, "pixel words back to back")

    // A write to the first-index register reads back on the next cycle.
    `ASSERT_NEXT(a_cfg_readback, clk, rst_n, psel && penable && pwrite && pready && paddr == 5'd0, paddr != 5'd0 || prdata[9:0] == $past(pwdata[9:0]), "register readback mismatch")

    // Without a request the front end stays idle.
    `ASSERT_NEXT(a_idle_stays, clk, rst_n, !busy && !start, !busy, "busy rose without a request")

endmodule

bind led_bar_gauge_wave_fill_core lbg_checker u_lbg_checker (.*);

@@ tb/sv/lbg_frame_checker.sv @@
// Frame checker: predicts the pixel words of each gauge frame and compares them.
module lbg_frame_checker #(
    parameter int MAX_LEDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [lbg_pkg::FILL_W-1:0]  fill_level,
    input  logic [lbg_pkg::TIME_W-1:0]  time_ms,
    input  logic [lbg_pkg::COLOR_W-1:0] base_red,
    input  logic [lbg_pkg::COLOR_W-1:0] base_green,
    input  logic [lbg_pkg::COLOR_W-1:0] base_blue,
    input  logic                        pixel_valid,
    input  logic [lbg_pkg::IDX_W-1:0]   led_index,
    input  logic [lbg_pkg::COLOR_W-1:0] pixel_red,
    input  logic [lbg_pkg::COLOR_W-1:0] pixel_green,
    input  logic [lbg_pkg::COLOR_W-1:0] pixel_blue,
    input  logic                        last_pixel,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output int                          mismatches,
    output int                          pixels_due
);
    import lbg_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   led;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } pixel_word_t;

    cfg_t        gauge_cfg;
    pixel_word_t frame_pixels_due[$];
    int          error_total = 0;
    int          lines_printed = 0;

    initial mismatches = 0;
    initial pixels_due = 0;

    function automatic logic [COLOR_W-1:0] scale_channel(input int unsigned c,
                                                         input int unsigned level);
        if (c == 0)
            return '0;
        return COLOR_W'(((c * level) >> 8) + (level != 0 ? 1 : 0));
    endfunction

    // Expands one frame request into the pixel words the block must emit.
    task automatic queue_frame_pixels(input logic [FILL_W-1:0] fill_in,
                                      input logic [TIME_W-1:0] t,
                                      input logic [COLOR_W-1:0] red,
                                      input logic [COLOR_W-1:0] green,
                                      input logic [COLOR_W-1:0] blue);
        logic              forward;
        int unsigned       len, lit, phase, span, level, pos, x;
        longint unsigned   fill, wave, w2, t_mod;
        int                tri_v;
        pixel_word_t       word;
        forward = gauge_cfg.seg_final >= gauge_cfg.seg_first;
        len = forward ? int'(gauge_cfg.seg_final) - int'(gauge_cfg.seg_first) + 1
                      : int'(gauge_cfg.seg_first) - int'(gauge_cfg.seg_final) + 1;
        if (len > MAX_LEDS)
            len = MAX_LEDS;
        fill = fill_in;
        if (fill > 65536)
            fill = 65536;
        lit = int'((fill * len + 32768) >> 16);
        if (fill > 0 && lit == 0)
            lit = 1;
        if (lit > len)
            lit = len;
        if (gauge_cfg.period == 0)
            phase = 0;
        else
        begin
            t_mod = t % gauge_cfg.period;
            phase = int'((t_mod << 16) / gauge_cfg.period);
        end
        span = gauge_cfg.bright_high > gauge_cfg.bright_low ?
               int'(gauge_cfg.bright_high) - int'(gauge_cfg.bright_low) : 0;
        for (int unsigned i = 0; i < len; i++)
        begin
            word.led = forward ? IDX_W'(gauge_cfg.seg_first + i)
                               : IDX_W'(gauge_cfg.seg_first - i);
            word.red = '0;
            word.green = '0;
            word.blue = '0;
            if (i < lit)
            begin
                pos = (i << 16) / lit;
                x = (pos - phase) & 32'hFFFF;
                tri_v = int'(2 * x) - 65536;
                wave = 65536 - (tri_v < 0 ? -tri_v : tri_v);
                w2 = (wave * wave) >> 16;
                level = gauge_cfg.bright_low + int'((w2 * span) >> 16);
                if (level > 255)
                    level = 255;
                word.red = scale_channel(red, level);
                word.green = scale_channel(green, level);
                word.blue = scale_channel(blue, level);
            end
            word.last = (i + 1 == len);
            frame_pixels_due.push_back(word);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_total++;
            // Keep the log readable when the block is badly broken.
            if (lines_printed < 150)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            lines_printed++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_word_t want;
        if (!rst_n)
        begin
            gauge_cfg.seg_first = '0;
            gauge_cfg.seg_final = IDX_W'(15);
            gauge_cfg.period = PERIOD_W'(1000);
            gauge_cfg.bright_low = COLOR_W'(20);
            gauge_cfg.bright_high = COLOR_W'(255);
            frame_pixels_due.delete();
            pixels_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SEG_FIRST:   gauge_cfg.seg_first = pwdata[IDX_W-1:0];
                    REG_SEG_FINAL:   gauge_cfg.seg_final = pwdata[IDX_W-1:0];
                    REG_PERIOD:      gauge_cfg.period = pwdata[PERIOD_W-1:0];
                    REG_BRIGHT_LOW:  gauge_cfg.bright_low = pwdata[COLOR_W-1:0];
                    REG_BRIGHT_HIGH: gauge_cfg.bright_high = pwdata[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                queue_frame_pixels(fill_level, time_ms, base_red, base_green, base_blue);
            if (pixel_valid)
            begin
                if (frame_pixels_due.size() == 0)
                begin
                    error_total++;
                    if (lines_printed < 150)
                        $display("%0t: word with none expected, expected none, actual led %0d",
                                 $time, led_index);
                    lines_printed++;
                end
                else
                begin
                    want = frame_pixels_due.pop_front();
                    check_field("led_index", want.led, led_index);
                    check_field("pixel_red", want.red, pixel_red);
                    check_field("pixel_green", want.green, pixel_green);
                    check_field("pixel_blue", want.blue, pixel_blue);
                    check_field("last_pixel", want.last, last_pixel);
                end
            end
            pixels_due <= frame_pixels_due.size();
        end
        mismatches <= error_total;
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives frame requests and register writes into the gauge core.
module tb;
    import lbg_pkg::*;

    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FILL_W-1:0]   fill_level = '0;
    logic [TIME_W-1:0]   time_ms = '0;
    logic [COLOR_W-1:0]  base_red = '0;
    logic [COLOR_W-1:0]  base_green = '0;
    logic [COLOR_W-1:0]  base_blue = '0;
    logic                pixel_valid;
    logic [IDX_W-1:0]    led_index;
    logic [COLOR_W-1:0]  pixel_red;
    logic [COLOR_W-1:0]  pixel_green;
    logic [COLOR_W-1:0]  pixel_blue;
    logic                last_pixel;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  mismatches;
    int                  pixels_due;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    led_bar_gauge_wave_fill_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .fill_level(fill_level), .time_ms(time_ms),
        .base_red(base_red), .base_green(base_green), .base_blue(base_blue),
        .pixel_valid(pixel_valid), .led_index(led_index),
        .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
        .last_pixel(last_pixel),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lbg_frame_checker pixel_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .fill_level(fill_level), .time_ms(time_ms),
        .base_red(base_red), .base_green(base_green), .base_blue(base_blue),
        .pixel_valid(pixel_valid), .led_index(led_index),
        .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
        .last_pixel(last_pixel),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .pixels_due(pixels_due)
    );

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle.
    task automatic apb_write(input logic [2:0] reg_sel, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Upper data bits are junk on purpose; the block must ignore them.
    task automatic set_config(input int first_led, input int last_led, input int period,
                              input int low, input int high);
        apb_write(REG_SEG_FIRST, {22'($urandom()), IDX_W'(first_led)});
        apb_write(REG_SEG_FINAL, {22'($urandom()), IDX_W'(last_led)});
        apb_write(REG_PERIOD, {16'($urandom()), PERIOD_W'(period)});
        apb_write(REG_BRIGHT_LOW, {24'($urandom()), COLOR_W'(low)});
        apb_write(REG_BRIGHT_HIGH, {24'($urandom()), COLOR_W'(high)});
    endtask

    // Presents one frame request and returns at the edge that accepts it.
    task automatic send_frame(input int unsigned fill, input logic [31:0] t,
                              input int red, input int green, input int blue);
        start <= 1'b1;
        fill_level <= FILL_W'(fill);
        time_ms <= t;
        base_red <= COLOR_W'(red);
        base_green <= COLOR_W'(green);
        base_blue <= COLOR_W'(blue);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Start must already be low; waits until every word has come out.
    task automatic drain_frames();
        do
            @(posedge clk);
        while (pixels_due != 0 || busy);
    endtask

    function automatic int pick_channel();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            2: return 1;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned pick_fill();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(65537, 131071);
            3: return $urandom_range(1, 300);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    task automatic random_config();
        int first_led, last_led, span_len, period;
        first_led = $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
            0, 1: span_len = $urandom_range(17, 64);
            2: span_len = $urandom_range(65, 1024);
            default: span_len = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 1) == 1)
            last_led = (first_led + span_len - 1 > 1023) ? 1023 : first_led + span_len - 1;
        else
            last_led = (first_led < span_len - 1) ? 0 : first_led - span_len + 1;
        case ($urandom_range(0, 9))
            0: period = 0;
            1: period = 1;
            2: period = 65535;
            default: period = $urandom_range(2, 5000);
        endcase
        set_config(first_led, last_led, period, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    initial
    begin
        int burst_left, gap, phase_items;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sixteen LEDs forward.
        send_frame(0, 32'd0, 255, 255, 255);
        send_frame(65536, 32'd0, 255, 255, 255);
        send_frame(131071, 32'hFFFF_FFFF, 1, 1, 1);
        send_frame(1, 32'd999, 0, 128, 255);
        send_frame(32768, 32'd500, 255, 0, 0);
        start <= 1'b0;
        drain_frames();
        // Writes to the spare addresses must leave the settings alone.
        for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
            apb_write(3'(r), 32'hFFFF_FFFF);
        send_frame(65536, 32'd12345, 200, 100, 50);
        start <= 1'b0;
        drain_frames();

        // Long reversed segment, zero period, zero brightness.
        set_config(1023, 0, 0, 0, 0);
        send_frame(65536, 32'd7, 255, 255, 255);
        send_frame(40000, 32'hFFFF_FFFF, 1, 2, 3);
        start <= 1'b0;
        drain_frames();

        // Long forward segment, ceiling under floor.
        set_config(0, 1023, 65535, 255, 0);
        send_frame(65536, 32'd65534, 255, 1, 0);
        send_frame(100, 32'd0, 7, 8, 9);
        start <= 1'b0;
        drain_frames();

        // Single LED, shortest period.
        set_config(500, 500, 1, 0, 255);
        send_frame(1, 32'd3, 255, 255, 255);
        send_frame(0, 32'd4, 255, 255, 255);
        send_frame(65536, 32'hFFFF_FFFF, 128, 64, 32);
        start <= 1'b0;
        drain_frames();

        // Short reversed segment with a flat full brightness.
        set_config(5, 0, 3, 255, 255);
        send_frame(30000, 32'd2, 255, 127, 1);
        send_frame(65536, 32'd1, 10, 20, 30);
        start <= 1'b0;
        drain_frames();

        for (int p = 0; p < 6; p++)
        begin
            random_config();
            phase_items = $urandom_range(17, 21);
            burst_left = $urandom_range(1, 10);
            for (int n = 0; n < phase_items; n++)
            begin
                send_frame(pick_fill(), $urandom(), pick_channel(), pick_channel(),
                           pick_channel());
                burst_left--;
                if (n == phase_items - 1)
                    start <= 1'b0;
                else if ($urandom_range(0, 11) == 0)
                begin
                    start <= 1'b0;
                    drain_frames();
                end
                else if (burst_left == 0)
                begin
                    start <= 1'b0;
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 1500)
                                                      : $urandom_range(1, 60);
                    repeat (gap) @(posedge clk);
                    burst_left = $urandom_range(1, 10);
                end
            end
            drain_frames();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && pixels_due == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lbg_pkg.sv
rtl/lbg_fifo.sv
rtl/lbg_front.sv
rtl/lbg_back.sv
rtl/led_bar_gauge_wave_fill_core.sv
rtl/lbg_checker.sv
tb/sv/lbg_frame_checker.sv
tb/sv/tb.sv
